FILE: src/lees_pkg.sv
package lees_pkg;

  localparam int FRAC_BITS = 20;
  localparam int WORD_BITS = 32;
  localparam int REG_W     = 32;
  localparam int DT_W      = 31;
  localparam int ADDR_W    = 5;
  localparam int OP_W      = WORD_BITS + 1;
  localparam int EXT_W     = 2 * OP_W;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [OP_W-1:0]      op_t;
  typedef logic signed [EXT_W-1:0]     ext_t;

  // Register reset values, Q12.20.
  localparam logic [REG_W-1:0] SIGMA_RST = 32'd10485760;
  localparam logic [REG_W-1:0] BETA_RST  = 32'd2796133;
  localparam logic [REG_W-1:0] RHO_RST   = 32'd20971520;
  localparam logic [DT_W-1:0]  DT_RST    = 31'd1049;
  localparam logic [REG_W-1:0] START_RST = 32'd1048576;

  typedef enum logic [2:0] {
    REG_SIGMA   = 3'd0,
    REG_BETA    = 3'd1,
    REG_RHO     = 3'd2,
    REG_STEP    = 3'd3,
    REG_START_X = 3'd4,
    REG_START_Y = 3'd5,
    REG_START_Z = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] sigma;
    logic [REG_W-1:0] beta;
    logic [REG_W-1:0] rho;
    logic [DT_W-1:0]  step_size;
    logic [REG_W-1:0] start_x;
    logic [REG_W-1:0] start_y;
    logic [REG_W-1:0] start_z;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_P1   = 3'd1,
    S_P2   = 3'd2,
    S_P3   = 3'd3,
    S_P4   = 3'd4,
    S_P5   = 3'd5
  } state_t;

  typedef struct packed {
    logic start;
    logic p1;
    logic p2;
    logic p3;
    logic p4;
    logic fin;
  } dp_cmd_t;

  // Saturate to the state word; the top bit of the result is the clip flag.
  function automatic logic [WORD_BITS:0] sat_word(input ext_t v);
    ext_t hi;
    ext_t lo;
    logic [WORD_BITS:0] r;
    hi = (ext_t'(1) <<< (WORD_BITS - 1)) - ext_t'(1);
    lo = -hi - ext_t'(1);
    if (v > hi) begin
      r = {1'b1, hi[WORD_BITS-1:0]};
    end else if (v < lo) begin
      r = {1'b1, lo[WORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    return r;
  endfunction

  // Clip to the 32-bit output range; the top bit is the clip flag.
  function automatic logic [REG_W:0] clip_out(input ext_t v);
    ext_t hi;
    ext_t lo;
    logic [REG_W:0] r;
    hi = (ext_t'(1) <<< (REG_W - 1)) - ext_t'(1);
    lo = -hi - ext_t'(1);
    if (v > hi) begin
      r = {1'b1, hi[REG_W-1:0]};
    end else if (v < lo) begin
      r = {1'b1, lo[REG_W-1:0]};
    end else begin
      r = {1'b0, v[REG_W-1:0]};
    end
    return r;
  endfunction

  // Fixed-point product, floored, saturated to the word.
  function automatic logic [WORD_BITS:0] mulq(input op_t a, input op_t b);
    ext_t p;
    p = (ext_t'(a) * ext_t'(b)) >>> FRAC_BITS;
    return sat_word(p);
  endfunction

endpackage

FILE: src/lees_cfg.sv
module lees_cfg import lees_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [REG_W-1:0]  cfg_pwdata,
  output logic [REG_W-1:0]  cfg_prdata,
  output logic              cfg_pready,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign regs       = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.sigma     <= SIGMA_RST;
      regs_r.beta      <= BETA_RST;
      regs_r.rho       <= RHO_RST;
      regs_r.step_size <= DT_RST;
      regs_r.start_x   <= START_RST;
      regs_r.start_y   <= START_RST;
      regs_r.start_z   <= START_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SIGMA:   regs_r.sigma     <= cfg_pwdata;
        REG_BETA:    regs_r.beta      <= cfg_pwdata;
        REG_RHO:     regs_r.rho       <= cfg_pwdata;
        REG_STEP:    regs_r.step_size <= cfg_pwdata[DT_W-1:0];
        REG_START_X: regs_r.start_x   <= cfg_pwdata;
        REG_START_Y: regs_r.start_y   <= cfg_pwdata;
        REG_START_Z: regs_r.start_z   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIGMA:   cfg_prdata = regs_r.sigma;
      REG_BETA:    cfg_prdata = regs_r.beta;
      REG_RHO:     cfg_prdata = regs_r.rho;
      REG_STEP:    cfg_prdata = {{(REG_W - DT_W){1'b0}}, regs_r.step_size};
      REG_START_X: cfg_prdata = regs_r.start_x;
      REG_START_Y: cfg_prdata = regs_r.start_y;
      REG_START_Z: cfg_prdata = regs_r.start_z;
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

FILE: src/lees_ctrl.sv
module lees_ctrl import lees_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_P1;
      S_P1:   state_nxt = S_P2;
      S_P2:   state_nxt = S_P3;
      S_P3:   state_nxt = S_P4;
      S_P4:   state_nxt = S_P5;
      // The last step waits here until the output register can take the beat.
      S_P5:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.start = in_accept;
    case (state_r)
      S_P1:    cmd.p1  = 1'b1;
      S_P2:    cmd.p2  = 1'b1;
      S_P3:    cmd.p3  = 1'b1;
      S_P4:    cmd.p4  = 1'b1;
      S_P5:    cmd.fin = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_P1)
    else $error("accepted item did not start the step sequence");

  a_fin_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P5 && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished step did not present a result beat");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P5 && !out_free) |=> (state_r == S_P5 && out_valid_r))
    else $error("final step left while the output register was occupied");

endmodule

FILE: src/lees_dp.sv
module lees_dp import lees_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  cfg_regs_t        regs,
  input  logic             in_restart,
  output logic [REG_W-1:0] out_x,
  output logic [REG_W-1:0] out_y,
  output logic [REG_W-1:0] out_z,
  output logic             out_saturated
);

  word_t x_r, y_r, z_r;
  word_t pa_r, pb_r;
  word_t dx_r, dy_r, dz_r;
  logic  flag_r;
  logic [REG_W-1:0] ox_r, oy_r, oz_r;
  logic  osat_r;

  word_t s_w, b_w, r_w, dt_w, sx_w, sy_w, sz_w;
  logic  fs, fb, fr, fdt, fsx, fsy, fsz;

  op_t ma_a, ma_b, mb_a, mb_b;
  word_t pa_w, pb_w;
  logic  fpa, fpb;

  word_t dy_w, dz_w, xn_w, yn_w, zn_w;
  logic  fdy, fdz, fxn, fyn, fzn;
  logic [REG_W-1:0] cx_w, cy_w, cz_w;
  logic  fcx, fcy, fcz;

  assign {fs, s_w}   = sat_word(ext_t'($signed(regs.sigma)));
  assign {fb, b_w}   = sat_word(ext_t'($signed(regs.beta)));
  assign {fr, r_w}   = sat_word(ext_t'($signed(regs.rho)));
  assign {fdt, dt_w} = sat_word(ext_t'({1'b0, regs.step_size}));
  assign {fsx, sx_w} = sat_word(ext_t'($signed(regs.start_x)));
  assign {fsy, sy_w} = sat_word(ext_t'($signed(regs.start_y)));
  assign {fsz, sz_w} = sat_word(ext_t'($signed(regs.start_z)));

  // Two shared multipliers; operands follow the step phase.
  always_comb begin
    ma_a = '0;
    ma_b = '0;
    mb_a = '0;
    mb_b = '0;
    if (cmd.p1) begin
      ma_a = op_t'(s_w);
      ma_b = op_t'(y_r) - op_t'(x_r);
      mb_a = op_t'(x_r);
      mb_b = op_t'(r_w) - op_t'(z_r);
    end else if (cmd.p2) begin
      ma_a = op_t'(x_r);
      ma_b = op_t'(y_r);
      mb_a = op_t'(b_w);
      mb_b = op_t'(z_r);
    end else if (cmd.p3) begin
      ma_a = op_t'(dt_w);
      ma_b = op_t'(dx_r);
      mb_a = op_t'(dt_w);
      mb_b = op_t'(dy_r);
    end else if (cmd.p4) begin
      ma_a = op_t'(dt_w);
      ma_b = op_t'(dz_r);
    end
  end

  assign {fpa, pa_w} = mulq(ma_a, ma_b);
  assign {fpb, pb_w} = mulq(mb_a, mb_b);

  assign {fdy, dy_w} = sat_word(ext_t'(pb_r) - ext_t'(y_r));
  assign {fdz, dz_w} = sat_word(ext_t'(pa_r) - ext_t'(pb_r));
  assign {fxn, xn_w} = sat_word(ext_t'(x_r) + ext_t'(pa_r));
  assign {fyn, yn_w} = sat_word(ext_t'(y_r) + ext_t'(pb_r));
  assign {fzn, zn_w} = sat_word(ext_t'(z_r) + ext_t'(pa_r));

  assign {fcx, cx_w} = clip_out(ext_t'(x_r));
  assign {fcy, cy_w} = clip_out(ext_t'(y_r));
  assign {fcz, cz_w} = clip_out(ext_t'(zn_w));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= word_t'(1) <<< FRAC_BITS;
      y_r    <= word_t'(1) <<< FRAC_BITS;
      z_r    <= word_t'(1) <<< FRAC_BITS;
      flag_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (in_restart) begin
          x_r    <= sx_w;
          y_r    <= sy_w;
          z_r    <= sz_w;
          flag_r <= fsx | fsy | fsz;
        end else begin
          flag_r <= 1'b0;
        end
      end
      if (cmd.p1) begin
        flag_r <= flag_r | fpa | fpb | fs | fb | fr | fdt;
      end
      if (cmd.p2) begin
        flag_r <= flag_r | fpa | fpb | fdy;
      end
      if (cmd.p3) begin
        flag_r <= flag_r | fpa | fpb | fdz;
      end
      if (cmd.p4) begin
        x_r    <= xn_w;
        y_r    <= yn_w;
        flag_r <= flag_r | fpa | fxn | fyn;
      end
      if (cmd.fin) begin
        z_r <= zn_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p1 || cmd.p2 || cmd.p3 || cmd.p4) begin
      pa_r <= pa_w;
    end
    if (cmd.p1 || cmd.p2 || cmd.p3) begin
      pb_r <= pb_w;
    end
    if (cmd.p2) begin
      dx_r <= pa_r;
      dy_r <= dy_w;
    end
    if (cmd.p3) begin
      dz_r <= dz_w;
    end
    if (cmd.fin) begin
      ox_r   <= cx_w;
      oy_r   <= cy_w;
      oz_r   <= cz_w;
      osat_r <= flag_r | fzn | fcx | fcy | fcz;
    end
  end

  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_saturated = osat_r;

endmodule

FILE: src/lorenz_euler_step.sv
// Lorenz attractor generator: one forward Euler step per input beat.
// Input channel: in_valid/in_stall with one field, in_restart. A beat with
// in_restart high reloads the point from the start_x/y/z registers before
// stepping; otherwise the step continues from the stored point.
// Output channel: out_valid/out_stall carrying out_x, out_y, out_z (Q12.20)
// and out_saturated, which is high when any value was clipped in that step.
// Configuration: APB-style port, registers sigma, beta, rho, step_size,
// start_x, start_y, start_z at byte addresses 0x00 to 0x18; write only
// while no step is in flight.
// Timing: an accepted beat runs five datapath phases on two shared
// multipliers (the products chain through s*(y-x), x*(rho-z), x*y, beta*z
// and then dt times each derivative). out_valid rises when the final phase
// loads the output register; in_stall is high until the step ends. The
// result sits in an output register, so a new beat is accepted while the
// previous result is still held; if that result is still stalled when the
// next step finishes, the step waits and in_stall stays high.
// Reset: the configuration registers take their defaults and the point is (1, 1, 1).
module lorenz_euler_step import lees_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [REG_W-1:0]  out_x,
  output logic [REG_W-1:0]  out_y,
  output logic [REG_W-1:0]  out_z,
  output logic              out_saturated,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [REG_W-1:0]  cfg_pwdata,
  output logic [REG_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  cfg_regs_t regs;
  dp_cmd_t   cmd;

  lees_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  lees_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lees_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .regs          (regs),
    .in_restart    (in_restart),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top import lees_pkg::*;;

  localparam int     CYCLE_LIMIT = 200000;
  localparam longint W_MAX       = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint W_MIN       = -W_MAX - 1;

  typedef struct packed {
    logic [REG_W-1:0] x;
    logic [REG_W-1:0] y;
    logic [REG_W-1:0] z;
    logic             sat;
  } point_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [REG_W-1:0]  out_x;
  logic [REG_W-1:0]  out_y;
  logic [REG_W-1:0]  out_z;
  logic              out_saturated;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [REG_W-1:0]  cfg_pwdata = '0;
  logic [REG_W-1:0]  cfg_prdata;
  logic              cfg_pready;

  // Mirror of the register file and of the stored trajectory point.
  cfg_regs_t cfg_model = {SIGMA_RST, BETA_RST, RHO_RST, DT_RST,
                          START_RST, START_RST, START_RST};
  longint    pt_x = longint'(1) <<< FRAC_BITS;
  longint    pt_y = longint'(1) <<< FRAC_BITS;
  longint    pt_z = longint'(1) <<< FRAC_BITS;
  bit        clip_seen;

  logic             pending_restarts [$];
  point_t           expected_points [$];
  point_t           due_point;
  logic [REG_W-1:0] next_cfg [7];
  int               send_idle = 29;
  int               recv_idle = 75;
  int               mismatches = 0;
  int               cycle_cnt = 0;

  lorenz_euler_step dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint sat_w(input longint v);
    if (v > W_MAX) begin
      clip_seen = 1'b1;
      return W_MAX;
    end
    if (v < W_MIN) begin
      clip_seen = 1'b1;
      return W_MIN;
    end
    return v;
  endfunction

  // Exact product, floored by the arithmetic shift, then clipped to the word.
  function automatic longint mul_q(input longint a, input longint b);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    logic signed [127:0] p;
    pa = 128'(a);
    pb = 128'(b);
    p = (pa * pb) >>> FRAC_BITS;
    if (p > W_MAX) begin
      clip_seen = 1'b1;
      return W_MAX;
    end
    if (p < W_MIN) begin
      clip_seen = 1'b1;
      return W_MIN;
    end
    return longint'(p);
  endfunction

  function automatic point_t euler_step(input logic restart);
    longint s, b, r, dt, x, y, z, dx, dy, dz;
    point_t res;
    clip_seen = 1'b0;
    if (restart) begin
      pt_x = sat_w(longint'($signed(cfg_model.start_x)));
      pt_y = sat_w(longint'($signed(cfg_model.start_y)));
      pt_z = sat_w(longint'($signed(cfg_model.start_z)));
    end
    s = sat_w(longint'($signed(cfg_model.sigma)));
    b = sat_w(longint'($signed(cfg_model.beta)));
    r = sat_w(longint'($signed(cfg_model.rho)));
    dt = longint'(cfg_model.step_size);
    dt = sat_w(dt);
    x = pt_x;
    y = pt_y;
    z = pt_z;
    // The differences y-x and rho-z enter the multiply at full width.
    dx = mul_q(s, y - x);
    dy = sat_w(mul_q(x, r - z) - y);
    dz = sat_w(mul_q(x, y) - mul_q(b, z));
    pt_x = sat_w(x + mul_q(dt, dx));
    pt_y = sat_w(y + mul_q(dt, dy));
    pt_z = sat_w(z + mul_q(dt, dz));
    res.x = pt_x[REG_W-1:0];
    res.y = pt_y[REG_W-1:0];
    res.z = pt_z[REG_W-1:0];
    res.sat = clip_seen;
    return res;
  endfunction

  // Input side: a beat is taken when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_restart <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(euler_step(in_restart));
      end
      if (!in_valid || !in_stall) begin
        if (pending_restarts.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid <= 1'b1;
          in_restart <= pending_restarts.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_restart <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // Output side: random stall, each taken beat checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result beat: x %h y %h z %h sat %b",
                 out_x, out_y, out_z, out_saturated);
          mismatches++;
        end else begin
          due_point = expected_points.pop_front();
          if (out_x !== due_point.x) begin
            $error("out_x: expected %h, actual %h", due_point.x, out_x);
            mismatches++;
          end
          if (out_y !== due_point.y) begin
            $error("out_y: expected %h, actual %h", due_point.y, out_y);
            mismatches++;
          end
          if (out_z !== due_point.z) begin
            $error("out_z: expected %h, actual %h", due_point.z, out_z);
            mismatches++;
          end
          if (out_saturated !== due_point.sat) begin
            $error("out_saturated: expected %b, actual %b", due_point.sat, out_saturated);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SIGMA:   cfg_model.sigma = val;
      REG_BETA:    cfg_model.beta = val;
      REG_RHO:     cfg_model.rho = val;
      REG_STEP:    cfg_model.step_size = val[DT_W-1:0];
      REG_START_X: cfg_model.start_x = val;
      REG_START_Y: cfg_model.start_y = val;
      REG_START_Z: cfg_model.start_z = val;
      default: ;
    endcase
  endtask

  task automatic load_cfg();
    for (int i = 0; i < 7; i++) begin
      cfg_write(reg_idx_t'(i), next_cfg[i]);
    end
  endtask

  // Registers may only change once the last step has drained out.
  task automatic wait_idle();
    while (pending_restarts.size() != 0 || in_valid || expected_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  // Parameters near the classic attractor, with a small dt so trajectories stay bounded.
  function automatic logic [REG_W-1:0] pick_classic(input reg_idx_t idx);
    int v;
    case (idx)
      REG_SIGMA: v = (10 << 20) + int'($urandom_range(0, 4 << 20)) - (2 << 20);
      REG_BETA:  v = 2796203 + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      REG_RHO:   v = (28 << 20) + int'($urandom_range(0, 16 << 20)) - (8 << 20);
      REG_STEP:  v = int'($urandom_range(1, 20000));
      default:   v = int'($urandom_range(0, 40 << 20)) - (20 << 20);
    endcase
    return v;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, continuing and restarting.
    foreach (next_cfg[i]) next_cfg[i] = '0;
    pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    wait_idle();

    // Largest magnitudes everywhere; dt written with bit 31 set, which is dropped.
    next_cfg = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    load_cfg();
    pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b1};
    wait_idle();

    next_cfg = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    load_cfg();
    pending_restarts = '{1'b1, 1'b0, 1'b1};
    wait_idle();

    foreach (next_cfg[i]) next_cfg[i] = '0;
    load_cfg();
    pending_restarts = '{1'b1, 1'b0};
    wait_idle();

    // Smallest nonzero dt from the top corner of the space.
    next_cfg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_cfg();
    pending_restarts = '{1'b1, 1'b0, 1'b0};
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 29 : 0;
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 7; i++) begin
          case (k)
            0, 1: next_cfg[i] = pick_classic(reg_idx_t'(i));
            2: next_cfg[i] = $urandom;
            default: next_cfg[i] = pick_edge();
          endcase
        end
        load_cfg();
        pending_restarts.push_back(1'b1);
        for (int j = 1; j < 40; j++) begin
          pending_restarts.push_back($urandom_range(0, 9) == 0);
        end
        wait_idle();
      end
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
